@@ rtl/plst_pkg.sv @@
// ----------------------------------------------------------------------------
// plst_pkg
// Shared sizes, command and status codes, controller states and word
// conversion helpers for the positional list store.
// ----------------------------------------------------------------------------
package plst_pkg;

	// Storage geometry.
	localparam int MAX_ENTRIES = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// Port field widths.
	localparam int CMD_W    = 3;
	localparam int POS_W    = 5;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Common width for comparing a position against the entry count.
	localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_HEAD   = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_LENGTH = 3'd4,
		CMD_LIST   = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK     = 2'd0,
		STS_BADPOS = 2'd1,
		STS_FULL   = 2'd2,
		STS_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOVE,
		ST_DRAIN,
		ST_FILL,
		ST_RESP,
		ST_LIST_RD,
		ST_LIST_WAIT
	} state_t;

	// Sign-extend or truncate a stored word to the output word width.
	function automatic logic [VAL_W-1:0] widen(logic [DATA_WIDTH-1:0] d);
		logic signed [DATA_WIDTH-1:0] s;
		s = d;
		return VAL_W'(s);
	endfunction

	// Sign-extend or truncate an input word to the stored word width.
	function automatic logic [DATA_WIDTH-1:0] narrow(logic [VAL_W-1:0] v);
		logic signed [VAL_W-1:0] s;
		s = v;
		return DATA_WIDTH'(s);
	endfunction

endpackage

@@ rtl/positional_list_store.sv @@
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed words held in a RAM plus an entry count.
// Supports append, add at head, insert after a position, delete at a
// position, length and a full listing.
//
//   Channel | Handshake             | Fields
//   --------+-----------------------+----------------------------------
//   in      | in_valid / in_ready   | command, position, value
//   out     | out_valid / out_ready | status, data_out, count, last
//
// Length, unused commands and rejected commands go from idle straight to the
// result state; append writes the word in the fill state. Insert and delete
// shift entries in the move and drain states, one RAM read and one RAM write
// per cycle; insert then writes its word in the fill state. List reads and
// loads each entry in turn. Reset clears state, count and output valid, not RAM.
// A stalled output holds the controller before the next word is loaded.
// ----------------------------------------------------------------------------
module positional_list_store
	import plst_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_W-1:0]    command,
	input  logic [POS_W-1:0]    position,
	input  logic [VAL_W-1:0]    value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [VAL_W-1:0]    data_out,
	output logic [COUNT_W-1:0]  count,
	output logic                last
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]      cnt_q;
	logic                  op_del_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      rp_q;
	logic [CNT_W-1:0]      reads_q;
	logic [DATA_WIDTH-1:0] val_q;
	status_t               res_status_q;
	logic [VAL_W-1:0]      res_data_q;

	logic                  rd_valid_s1;
	logic [IDX_W-1:0]      rd_addr_s1;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [VAL_W-1:0]      out_data_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic                  out_last_q;

	// Decode results for the word at the input.
	state_t                dec_next;
	status_t               dec_status;
	logic                  dec_del;
	logic [IDX_W-1:0]      dec_idx;
	logic [IDX_W-1:0]      dec_rp;
	logic [CNT_W-1:0]      dec_reads;

	logic                  in_fire;
	logic                  out_free;
	logic                  list_last;
	logic                  is_empty;
	logic                  is_full;
	logic                  bad_pos;
	logic [CMP_W-1:0]      pos_c;
	logic [CMP_W-1:0]      cnt_c;
	cmd_t                  cmd_in;

	// RAM port signals and controller strobes.
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic                  mem_re;
	logic [DATA_WIDTH-1:0] mem_rdata;
	logic                  capture_s1;
	logic                  load_resp;
	logic                  load_list;

	plst_ram #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rp_q),
		.rdata (mem_rdata)
	);

	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign list_last = (CNT_W'(rp_q) + CNT_W'(1)) == cnt_q;

	// Command checks against the current count.
	assign cmd_in   = cmd_t'(command);
	assign pos_c    = CMP_W'(position);
	assign cnt_c    = CMP_W'(cnt_q);
	assign is_empty = (cnt_q == '0);
	assign is_full  = (cnt_q == CNT_W'(MAX_ENTRIES));
	assign bad_pos  = (pos_c == '0) || (pos_c > cnt_c);

	// Plan the work for the incoming command.
	always_comb begin
		dec_next   = ST_RESP;
		dec_status = STS_OK;
		dec_del    = 1'b0;
		dec_idx    = '0;
		dec_rp     = '0;
		dec_reads  = '0;
		unique case (cmd_in)
			CMD_APPEND: begin
				if (is_full) begin
					dec_status = STS_FULL;
				end else begin
					dec_idx  = IDX_W'(cnt_q);
					dec_next = ST_FILL;
				end
			end
			CMD_HEAD: begin
				if (is_full) begin
					dec_status = STS_FULL;
				end else begin
					dec_idx   = '0;
					dec_reads = cnt_q;
					dec_rp    = IDX_W'(cnt_q - CNT_W'(1));
					dec_next  = is_empty ? ST_FILL : ST_MOVE;
				end
			end
			CMD_INSERT: begin
				priority if (is_empty) begin
					dec_status = STS_EMPTY;
				end else if (bad_pos) begin
					dec_status = STS_BADPOS;
				end else if (is_full) begin
					dec_status = STS_FULL;
				end else begin
					dec_idx   = IDX_W'(position);
					dec_reads = CNT_W'(cnt_c - pos_c);
					dec_rp    = IDX_W'(cnt_q - CNT_W'(1));
					dec_next  = (cnt_c == pos_c) ? ST_FILL : ST_MOVE;
				end
			end
			CMD_DELETE: begin
				priority if (is_empty) begin
					dec_status = STS_EMPTY;
				end else if (bad_pos) begin
					dec_status = STS_BADPOS;
				end else begin
					dec_del   = 1'b1;
					dec_idx   = IDX_W'(pos_c - CMP_W'(1));
					dec_rp    = IDX_W'(pos_c - CMP_W'(1));
					dec_reads = CNT_W'(cnt_c - pos_c + CMP_W'(1));
					dec_next  = ST_MOVE;
				end
			end
			CMD_LIST: begin
				if (is_empty) begin
					dec_status = STS_EMPTY;
				end else begin
					dec_rp   = '0;
					dec_next = ST_LIST_RD;
				end
			end
			default: begin
				dec_status = STS_OK;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = dec_next;
				end
			end
			ST_MOVE: begin
				if (reads_q == CNT_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = op_del_q ? ST_RESP : ST_FILL;
			end
			ST_FILL: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_LIST_RD: begin
				if (out_free) begin
					state_d = ST_LIST_WAIT;
				end
			end
			ST_LIST_WAIT: begin
				state_d = list_last ? ST_IDLE : ST_LIST_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Controller outputs: RAM accesses and result loads.
	always_comb begin
		in_ready   = 1'b0;
		mem_re     = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = mem_rdata;
		load_resp  = 1'b0;
		load_list  = 1'b0;
		capture_s1 = rd_valid_s1 && op_del_q && (rd_addr_s1 == idx_q);
		unique case (state_q)
			ST_IDLE:      in_ready  = 1'b1;
			ST_MOVE:      mem_re    = 1'b1;
			ST_LIST_RD:   mem_re    = out_free;
			ST_LIST_WAIT: load_list = 1'b1;
			ST_RESP:      load_resp = out_free;
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = val_q;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
		// Write back the word read in the previous cycle, one slot along.
		if (rd_valid_s1 && !capture_s1) begin
			mem_we    = 1'b1;
			mem_waddr = op_del_q ? (rd_addr_s1 - IDX_W'(1)) : (rd_addr_s1 + IDX_W'(1));
			mem_wdata = mem_rdata;
		end
	end

	// Controller state and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= (state_q == ST_MOVE);
			if (state_q == ST_FILL) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (state_q == ST_DRAIN && op_del_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Command context and walk pointers.
	always_ff @(posedge clk) begin
		rd_addr_s1 <= rp_q;
		if (in_fire) begin
			op_del_q     <= dec_del;
			idx_q        <= dec_idx;
			rp_q         <= dec_rp;
			reads_q      <= dec_reads;
			val_q        <= narrow(value);
			res_status_q <= dec_status;
			res_data_q   <= '0;
		end else if (state_q == ST_MOVE) begin
			rp_q    <= op_del_q ? (rp_q + IDX_W'(1)) : (rp_q - IDX_W'(1));
			reads_q <= reads_q - CNT_W'(1);
		end else if (load_list) begin
			rp_q <= rp_q + IDX_W'(1);
		end
		// Keep the word that a delete removes.
		if (capture_s1) begin
			res_data_q <= widen(mem_rdata);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_resp || load_list) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_resp) begin
			out_status_q <= res_status_q;
			out_data_q   <= res_data_q;
			out_count_q  <= COUNT_W'(cnt_q);
			out_last_q   <= 1'b1;
		end else if (load_list) begin
			out_status_q <= STS_OK;
			out_data_q   <= widen(mem_rdata);
			out_count_q  <= COUNT_W'(cnt_q);
			out_last_q   <= list_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign data_out  = out_data_q;
	assign count     = out_count_q;
	assign last      = out_last_q;

`ifndef SYNTHESIS
	// The entry count never passes the store depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count exceeds store depth");

	// An accepted command always leaves the idle state.
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != ST_IDLE)
		else $error("accepted command did not start work");

	// Shift reads return only while a move is running or draining.
	a_s1_window: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == ST_MOVE || state_q == ST_DRAIN))
		else $error("shift read data outside a move");

	// A list word is loaded only into an empty output register.
	a_list_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_list |-> !out_valid_q)
		else $error("list word would overwrite a pending result");
`endif

endmodule

@@ rtl/plst_ram.sv @@
// ----------------------------------------------------------------------------
// plst_ram
// Simple dual-port synchronous RAM: one write port, one read port, read
// data registered.
// ----------------------------------------------------------------------------
module plst_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ tb/tb_positional_list_store.sv @@
// ----------------------------------------------------------------------------
// tb_positional_list_store
// Self-checking testbench for the positional list store. A behavioral copy of
// the list predicts every result word from each accepted command word; a
// checker compares each returned word field by field with the oldest pending
// prediction. Directed tests cover the empty list, extreme words, bad
// positions and a full store; random traffic then runs under several idle
// and stall mixes on both channels.
// ----------------------------------------------------------------------------
module tb_positional_list_store;
	import plst_pkg::*;

	// Command codes that the block does not define; they behave like length.
	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

	localparam logic [VAL_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] WORD_MIN  = 32'h8000_0000;
	localparam logic [VAL_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VAL_W-1:0]    data;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} list_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [CMD_W-1:0]    command;
	logic [POS_W-1:0]    position;
	logic [VAL_W-1:0]    value;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic [VAL_W-1:0]    data_out;
	logic [COUNT_W-1:0]  count;
	logic                last;

	// Predicted list contents and the queue of results still to arrive.
	logic [DATA_WIDTH-1:0] list_words [MAX_ENTRIES];
	int                    list_len;
	list_result_t          pending_results [$];

	int idle_pct;
	int stall_pct;
	int mismatches;
	int words_sent;
	int results_checked;
	int full_rejects;
	int peak_len;
	int cycle_count;

	positional_list_store uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.data_out  (data_out),
		.count     (count),
		.last      (last)
	);

	// Clock with a period of 8.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Print one mismatch line, up to a cap, and count it.
	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s expected %0h got %0h",
				cycle_count, what, want, got);
		mismatches++;
	endtask

	task automatic push_result(input status_t sts, input logic [VAL_W-1:0] data,
			input logic fin);
		list_result_t r;
		r.status = sts;
		r.data   = data;
		r.count  = COUNT_W'(list_len);
		r.last   = fin;
		if (sts == STS_FULL)
			full_rejects++;
		pending_results.push_back(r);
	endtask

	// Shift entries up from idx and place a new word there.
	task automatic open_gap(input int idx, input logic [DATA_WIDTH-1:0] w);
		for (int i = list_len; i > idx; i--)
			list_words[i] = list_words[i - 1];
		list_words[idx] = w;
		list_len++;
		if (list_len > peak_len)
			peak_len = list_len;
	endtask

	// Work out the result words of one accepted command word.
	task automatic predict_list_results(input logic [CMD_W-1:0] cmd,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val);
		logic [DATA_WIDTH-1:0] stored;
		logic [DATA_WIDTH-1:0] taken;
		int                    p;
		stored = DATA_WIDTH'($signed(val));
		p = int'(pos);
		case (cmd)
		CMD_APPEND, CMD_HEAD: begin
			if (list_len >= MAX_ENTRIES) begin
				push_result(STS_FULL, '0, 1'b1);
			end else begin
				open_gap((cmd == CMD_APPEND) ? list_len : 0, stored);
				push_result(STS_OK, '0, 1'b1);
			end
		end
		CMD_INSERT: begin
			// An empty list and a bad position are checked before a full store.
			if (list_len == 0)
				push_result(STS_EMPTY, '0, 1'b1);
			else if (p == 0 || p > list_len)
				push_result(STS_BADPOS, '0, 1'b1);
			else if (list_len >= MAX_ENTRIES)
				push_result(STS_FULL, '0, 1'b1);
			else begin
				open_gap(p, stored);
				push_result(STS_OK, '0, 1'b1);
			end
		end
		CMD_DELETE: begin
			if (list_len == 0) begin
				push_result(STS_EMPTY, '0, 1'b1);
			end else if (p == 0 || p > list_len) begin
				push_result(STS_BADPOS, '0, 1'b1);
			end else begin
				taken = list_words[p - 1];
				for (int i = p - 1; i + 1 < list_len; i++)
					list_words[i] = list_words[i + 1];
				list_len--;
				push_result(STS_OK, VAL_W'($signed(taken)), 1'b1);
			end
		end
		CMD_LIST: begin
			if (list_len == 0) begin
				push_result(STS_EMPTY, '0, 1'b1);
			end else begin
				for (int i = 0; i < list_len; i++)
					push_result(STS_OK, VAL_W'($signed(list_words[i])),
						i + 1 == list_len);
			end
		end
		default: begin
			// Length and the unused codes report the current count.
			push_result(STS_OK, '0, 1'b1);
		end
		endcase
	endtask

	// Present one command word and wait until the block takes it.
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		position <= pos;
		value    <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_list_results(cmd, pos, val);
		words_sent++;
	endtask

	// Hold the sender off until every predicted result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver stalls at the current rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", '0,
					{status, data_out, count, last});
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", want.status, status);
				if (data_out !== want.data)
					report_mismatch("data_out", want.data, data_out);
				if (count !== want.count)
					report_mismatch("count", want.count, count);
				if (last !== want.last)
					report_mismatch("last", want.last, last);
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL");
			$finish;
		end
	end

	// Commands on an empty list.
	task automatic test_empty_list();
		send_word(CMD_DELETE, 5'd1, $urandom);
		send_word(CMD_INSERT, 5'd1, $urandom);
		send_word(CMD_LIST, 5'd0, '0);
		send_word(CMD_LENGTH, 5'd31, WORD_ONES);
		send_word(CMD_SPARE7, 5'd31, $urandom);
		drain_results();
	endtask

	// Extreme words and bad positions on a short list.
	task automatic test_edge_words();
		send_word(CMD_APPEND, 5'd0, WORD_MAX);
		send_word(CMD_HEAD, 5'd0, WORD_MIN);
		send_word(CMD_APPEND, 5'd0, WORD_ONES);
		send_word(CMD_INSERT, 5'd0, $urandom);
		send_word(CMD_INSERT, 5'd4, $urandom);
		send_word(CMD_INSERT, 5'd2, '0);
		send_word(CMD_DELETE, 5'd0, '0);
		send_word(CMD_DELETE, 5'd5, '0);
		send_word(CMD_DELETE, 5'd4, '0);
		send_word(CMD_DELETE, 5'd1, '0);
		send_word(CMD_LIST, 5'd0, '0);
		drain_results();
	endtask

	// Fill the store, check that every add is turned away, then list it and delete the last entry.
	task automatic test_full_store();
		int pick;
		while (list_len < MAX_ENTRIES) begin
			pick = $urandom_range(0, 2);
			if (pick == 0)
				send_word(CMD_APPEND, 5'd0, $urandom);
			else if (pick == 1)
				send_word(CMD_HEAD, 5'd0, $urandom);
			else
				send_word(CMD_INSERT, POS_W'(list_len), $urandom);
		end
		send_word(CMD_APPEND, 5'd0, $urandom);
		send_word(CMD_HEAD, 5'd0, $urandom);
		send_word(CMD_INSERT, 5'd0, $urandom);
		send_word(CMD_INSERT, 5'd16, $urandom);
		send_word(CMD_LIST, 5'd0, '0);
		send_word(CMD_DELETE, 5'd16, '0);
		drain_results();
	endtask

	// Random traffic that drifts between growing and shrinking the list.
	task automatic test_random_traffic(input int n_words, input int idle,
			input int stall, input bit pause_midway);
		int               r;
		int               pp;
		bit               growing;
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		idle_pct  = idle;
		stall_pct = stall;
		growing   = 1'b1;
		for (int n = 0; n < n_words; n++) begin
			if (list_len == MAX_ENTRIES)
				growing = 1'b0;
			else if (list_len == 0)
				growing = 1'b1;
			else if ($urandom_range(0, 99) < 5)
				growing = !growing;

			r = $urandom_range(0, 99);
			if (r < 4)
				cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
			else if (r < 12)
				cmd = CMD_LENGTH;
			else if (r < 20)
				cmd = CMD_LIST;
			else if (growing)
				cmd = (r < 45) ? CMD_APPEND : (r < 65) ? CMD_HEAD :
					(r < 90) ? CMD_INSERT : CMD_DELETE;
			else
				cmd = (r < 30) ? CMD_APPEND : (r < 38) ? CMD_INSERT : CMD_DELETE;

			// Mostly valid positions, with zero, one past the end and noise.
			pp = $urandom_range(0, 99);
			if (pp < 70 && list_len > 0)
				pos = POS_W'($urandom_range(1, list_len));
			else if (pp < 80)
				pos = '0;
			else if (pp < 90)
				pos = POS_W'(list_len + 1);
			else
				pos = POS_W'($urandom_range(0, 31));

			case ($urandom_range(0, 19))
			0:       val = WORD_MAX;
			1:       val = WORD_MIN;
			2:       val = WORD_ONES;
			3:       val = '0;
			default: val = $urandom;
			endcase

			send_word(cmd, pos, val);
			if (pause_midway && n == n_words / 2)
				drain_results();
		end
		drain_results();
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		command         = '0;
		position        = '0;
		value           = '0;
		out_ready       = 1'b0;
		idle_pct        = 0;
		stall_pct       = 0;
		mismatches      = 0;
		words_sent      = 0;
		results_checked = 0;
		full_rejects    = 0;
		peak_len        = 0;
		cycle_count     = 0;
		list_len        = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edge_words();
		idle_pct  = 25;
		stall_pct = 25;
		test_full_store();

		test_random_traffic(80, 0, 0, 1'b0);
		test_random_traffic(80, 72, 0, 1'b0);
		test_random_traffic(80, 0, 72, 1'b1);
		test_random_traffic(80, 25, 25, 1'b0);

		// Let any stray result surface before the verdict.
		idle_pct  = 0;
		stall_pct = 0;
		repeat (2 * MAX_ENTRIES + 8) @(posedge clk);

		if (pending_results.size() != 0)
			report_mismatch("results never returned", pending_results.size(), '0);

		$display("Covered %0d command words and %0d result words under four idle mixes.",
			words_sent, results_checked);
		$display("Peak list length %0d, %0d full-store rejections, %0d mismatches.",
			peak_len, full_rejects, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
